// File: design/cmam_pkg.sv
// Shared constants and types for the centered moving average block.
`timescale 1ns / 1ps

package cmam_pkg;

  localparam int SAMPLE_BITS   = 32;
  localparam int MAX_HALF      = 31;
  localparam int RING_DEPTH    = 2 * MAX_HALF + 1;
  localparam int ADDR_BITS     = $clog2(RING_DEPTH);
  localparam int CNT_BITS      = $clog2(RING_DEPTH + 1);
  localparam int HALF_BITS     = $clog2(MAX_HALF + 1);
  localparam int SUM_BITS      = SAMPLE_BITS + CNT_BITS;
  localparam int STEP_BITS     = $clog2(SUM_BITS + 1);
  localparam int ENTRY_BITS    = SAMPLE_BITS + 1;
  localparam int TDATA_BITS    = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int WINDOW_BITS   = 6;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 3;

  localparam logic [CFG_ADDR_BITS-3:0] REG_WINDOW = '0;
  localparam logic [WINDOW_BITS-1:0]   WINDOW_RESET = WINDOW_BITS'(1);

  typedef struct packed {
    logic start;
    logic eoc;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [SAMPLE_BITS-1:0] mean;
    logic                   mean_valid;
    logic                   eoc;
  } div_rsp_t;

endpackage

// File: design/cmam_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module cmam_ram #(
  parameter int DEPTH     = 63,
  parameter int WIDTH     = 33,
  parameter int ADDR_BITS = 6
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/cmam_div.sv
// Bit-serial rounded signed divider of the window sum by the valid count.
`timescale 1ns / 1ps

module cmam_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cmam_pkg::div_req_t               req,
  input  logic [cmam_pkg::SUM_BITS-1:0]    sum,
  input  logic [cmam_pkg::CNT_BITS-1:0]    count,
  output cmam_pkg::div_rsp_t               rsp
);

  localparam int SB = cmam_pkg::SUM_BITS;
  localparam int CB = cmam_pkg::CNT_BITS;
  localparam int QB = cmam_pkg::SAMPLE_BITS;

  logic                 busy_r, busy_nxt;
  logic                 fin_r, fin_nxt;
  logic                 done_r, done_nxt;
  logic [cmam_pkg::STEP_BITS-1:0] step_r, step_nxt;
  logic [SB-1:0]        dvd_r, dvd_nxt;
  logic [CB-1:0]        rem_r, rem_nxt;
  logic [CB-1:0]        n_r, n_nxt;
  logic                 neg_r, neg_nxt;
  logic                 eoc_r, eoc_nxt;
  logic [QB-1:0]        mean_r, mean_nxt;
  logic                 mvalid_r, mvalid_nxt;

  logic                 neg_in;
  logic [CB-1:0]        round_add;
  logic [CB+1:0]        shifted;
  logic [CB+1:0]        diff;
  logic                 ge;
  logic [QB-1:0]        quot;

  assign neg_in    = sum[SB-1];
  assign round_add = {1'b0, count[CB-1:1]} + CB'(neg_in);
  assign shifted   = {1'b0, rem_r, dvd_r[SB-1]};
  assign diff      = shifted - {2'b00, n_r};
  assign ge        = ~diff[CB+1];
  assign quot      = dvd_r[QB-1:0];

  always_comb begin
    busy_nxt   = busy_r;
    fin_nxt    = 1'b0;
    done_nxt   = 1'b0;
    step_nxt   = step_r;
    dvd_nxt    = dvd_r;
    rem_nxt    = rem_r;
    n_nxt      = n_r;
    neg_nxt    = neg_r;
    eoc_nxt    = eoc_r;
    mean_nxt   = mean_r;
    mvalid_nxt = mvalid_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      n_nxt    = count;
      neg_nxt  = neg_in;
      eoc_nxt  = req.eoc;
      dvd_nxt  = (neg_in ? ~sum : sum) + {{(SB-CB){1'b0}}, round_add};
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[CB-1:0] : shifted[CB-1:0];
      dvd_nxt  = {dvd_r[SB-2:0], ge};
      step_nxt = step_r + 1'b1;
      if (step_r == cmam_pkg::STEP_BITS'(SB - 1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end
    if (fin_r) begin
      done_nxt   = 1'b1;
      mvalid_nxt = (n_r != '0);
      if (n_r == '0) begin
        mean_nxt = '0;
      end else if (neg_r) begin
        mean_nxt = ~quot + 1'b1;
      end else begin
        mean_nxt = quot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r   <= step_nxt;
    dvd_r    <= dvd_nxt;
    rem_r    <= rem_nxt;
    n_r      <= n_nxt;
    neg_r    <= neg_nxt;
    eoc_r    <= eoc_nxt;
    mean_r   <= mean_nxt;
    mvalid_r <= mvalid_nxt;
  end

  assign rsp.done       = done_r;
  assign rsp.mean       = mean_r;
  assign rsp.mean_valid = mvalid_r;
  assign rsp.eoc        = eoc_r;

endmodule

// File: design/centered_moving_average_missing_unit.sv
// Top level: sample ring, window summation sequencer, divider and output register.
//
//  channel | direction | beat contents
//  in_     | slave     | tdata: sample; tuser: sample_valid; tlast: last
//  out_    | master    | tdata: mean; tuser: mean_valid; tlast: end_of_curve
//  cfg_    | APB slave | register 0 at byte 0: window[5:0]
//
// An input beat that forms no result leaves the sequencer idle. Each result
// takes span+1 ring reads through the single RAM read port, then 38 divider
// steps; a last beat forms up to half+1 results in turn.
// Synchronous active-low reset; the ring needs no clearing pass.
// in_tready is high only while the sequencer is idle; a result waiting in the
// output register stalls only the start of the next division.
`timescale 1ns / 1ps

module centered_moving_average_missing_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [cmam_pkg::TDATA_BITS-1:0]       in_tdata,   // sample
  input  logic                                  in_tuser,   // sample_valid
  input  logic                                  in_tlast,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [cmam_pkg::TDATA_BITS-1:0]       out_tdata,  // mean
  output logic                                  out_tuser,  // mean_valid
  output logic                                  out_tlast,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [cmam_pkg::CFG_ADDR_BITS-1:0]    cfg_paddr,
  input  logic [cmam_pkg::CFG_DATA_BITS-1:0]    cfg_pwdata,
  output logic [cmam_pkg::CFG_DATA_BITS-1:0]    cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int AB = cmam_pkg::ADDR_BITS;
  localparam int CB = cmam_pkg::CNT_BITS;
  localparam int HB = cmam_pkg::HALF_BITS;
  localparam int SB = cmam_pkg::SUM_BITS;
  localparam int QB = cmam_pkg::SAMPLE_BITS;
  localparam int WB = cmam_pkg::WINDOW_BITS;
  localparam int CA = cmam_pkg::CFG_ADDR_BITS;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SUM   = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_LOAD  = 5'b01000,
    ST_DIV   = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [WB-1:0]     window_r, window_nxt;
  logic [AB-1:0]     pos_r, pos_nxt;
  logic [AB-1:0]     newest_r, newest_nxt;
  logic [AB-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CB-1:0]     seen_r, seen_nxt;
  logic [CB-1:0]     span_r, span_nxt;
  logic [CB-1:0]     d_r, d_nxt;
  logic [HB-1:0]     lag_r, lag_nxt;
  logic              flush_r, flush_nxt;
  logic [SB-1:0]     sum_r, sum_nxt;
  logic [CB-1:0]     cnt_r, cnt_nxt;
  logic              rd_v_r, rd_v_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [QB-1:0]     out_mean_r, out_mean_nxt;
  logic              out_mvalid_r, out_mvalid_nxt;
  logic              out_eoc_r, out_eoc_nxt;

  logic                        in_acc;
  logic                        cfg_wr;
  logic [HB-1:0]               half;
  logic [CB-1:0]               seen_inc;
  logic [CB-1:0]               seen_m1;
  logic [CB-1:0]               lag_seed;
  logic [CB-1:0]               span_cand;
  logic [HB-1:0]               lag_dec;
  logic [CB-1:0]               flush_span;
  logic                        rd_en;
  logic [cmam_pkg::ENTRY_BITS-1:0] rd_data;
  logic [SB-1:0]               rd_ext;
  cmam_pkg::div_req_t          div_req;
  cmam_pkg::div_rsp_t          div_rsp;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[CA-1:2] == cmam_pkg::REG_WINDOW)
                      ? {{(cmam_pkg::CFG_DATA_BITS-WB){1'b0}}, window_r} : '0;

  assign half     = window_r[WB-1:1];
  assign seen_inc = (seen_r == CB'(cmam_pkg::RING_DEPTH)) ? seen_r : seen_r + 1'b1;
  assign seen_m1  = seen_inc - 1'b1;
  assign lag_seed = ({1'b0, half} > seen_m1) ? seen_m1 : {1'b0, half};
  assign span_cand = ({half, 1'b0} > seen_m1) ? seen_m1 : {half, 1'b0};
  assign lag_dec  = lag_r - 1'b1;
  assign flush_span = (({1'b0, lag_dec} + {1'b0, half}) > (seen_r - 1'b1))
                      ? seen_r - 1'b1 : {1'b0, lag_dec} + {1'b0, half};

  assign rd_en  = (state_r == ST_SUM);
  assign rd_ext = {{(SB-QB){rd_data[QB-1]}}, rd_data[QB-1:0]};

  cmam_ram #(
    .DEPTH     (cmam_pkg::RING_DEPTH),
    .WIDTH     (cmam_pkg::ENTRY_BITS),
    .ADDR_BITS (AB)
  ) u_ring (
    .clk   (clk),
    .we    (in_acc),
    .waddr (pos_r),
    .wdata ({in_tuser, in_tdata[QB-1:0]}),
    .re    (rd_en),
    .raddr (rd_ptr_r),
    .rdata (rd_data)
  );

  assign div_req.start = (state_r == ST_LOAD) && !out_valid_r;
  assign div_req.eoc   = flush_r && (lag_r == '0);

  cmam_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .sum   (sum_r),
    .count (cnt_r),
    .rsp   (div_rsp)
  );

  always_comb begin
    state_nxt      = state_r;
    window_nxt     = window_r;
    pos_nxt        = pos_r;
    newest_nxt     = newest_r;
    rd_ptr_nxt     = rd_ptr_r;
    seen_nxt       = seen_r;
    span_nxt       = span_r;
    d_nxt          = d_r;
    lag_nxt        = lag_r;
    flush_nxt      = flush_r;
    sum_nxt        = sum_r;
    cnt_nxt        = cnt_r;
    rd_v_nxt       = rd_en;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_mean_nxt   = out_mean_r;
    out_mvalid_nxt = out_mvalid_r;
    out_eoc_nxt    = out_eoc_r;

    if (cfg_wr && (cfg_paddr[CA-1:2] == cmam_pkg::REG_WINDOW)) begin
      window_nxt = cfg_pwdata[WB-1:0];
    end

    if (rd_v_r && rd_data[QB]) begin
      sum_nxt = sum_r + rd_ext;
      cnt_nxt = cnt_r + 1'b1;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          pos_nxt    = (pos_r == AB'(cmam_pkg::RING_DEPTH - 1)) ? '0 : pos_r + 1'b1;
          newest_nxt = pos_r;
          rd_ptr_nxt = pos_r;
          seen_nxt   = seen_inc;
          sum_nxt    = '0;
          cnt_nxt    = '0;
          d_nxt      = '0;
          if (in_tlast) begin
            flush_nxt = 1'b1;
            lag_nxt   = lag_seed[HB-1:0];
            span_nxt  = ((lag_seed + {1'b0, half}) > seen_m1)
                        ? seen_m1 : lag_seed + {1'b0, half};
            state_nxt = ST_SUM;
          end else if (seen_inc >= ({1'b0, half} + 1'b1)) begin
            flush_nxt = 1'b0;
            lag_nxt   = '0;
            span_nxt  = span_cand;
            state_nxt = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        rd_ptr_nxt = (rd_ptr_r == '0) ? AB'(cmam_pkg::RING_DEPTH - 1) : rd_ptr_r - 1'b1;
        d_nxt      = d_r + 1'b1;
        if (d_r == span_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (!out_valid_r) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          out_valid_nxt  = 1'b1;
          out_mean_nxt   = div_rsp.mean;
          out_mvalid_nxt = div_rsp.mean_valid;
          out_eoc_nxt    = div_rsp.eoc;
          if (flush_r && (lag_r != '0)) begin
            lag_nxt    = lag_dec;
            span_nxt   = flush_span;
            rd_ptr_nxt = newest_r;
            sum_nxt    = '0;
            cnt_nxt    = '0;
            d_nxt      = '0;
            state_nxt  = ST_SUM;
          end else begin
            if (flush_r) begin
              seen_nxt = '0;
            end
            flush_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      window_r    <= cmam_pkg::WINDOW_RESET;
      pos_r       <= '0;
      seen_r      <= '0;
      flush_r     <= 1'b0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      window_r    <= window_nxt;
      pos_r       <= pos_nxt;
      seen_r      <= seen_nxt;
      flush_r     <= flush_nxt;
      rd_v_r      <= rd_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    newest_r     <= newest_nxt;
    rd_ptr_r     <= rd_ptr_nxt;
    span_r       <= span_nxt;
    d_r          <= d_nxt;
    lag_r        <= lag_nxt;
    sum_r        <= sum_nxt;
    cnt_r        <= cnt_nxt;
    out_mean_r   <= out_mean_nxt;
    out_mvalid_r <= out_mvalid_nxt;
    out_eoc_r    <= out_eoc_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(cmam_pkg::TDATA_BITS-QB){1'b0}}, out_mean_r};
  assign out_tuser  = out_mvalid_r;
  assign out_tlast  = out_eoc_r;

`ifndef SYNTHESIS
  a_start_into_empty_output: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !out_valid_r)
    else $error("division started while output register is full");

  a_done_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV))
    else $error("divider result arrived outside the division state");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (rd_ptr_r < AB'(cmam_pkg::RING_DEPTH)))
    else $error("ring read pointer out of range");

  a_read_data_while_summing: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> ((state_r == ST_SUM) || (state_r == ST_DRAIN)))
    else $error("ring read data returned outside summation");
`endif

endmodule
